>>> hw/rtl/byte_budget_lru_cache_manager_defines.svh
// Assertion helpers for the cache manager.
`ifndef BYTE_BUDGET_LRU_CACHE_MANAGER_DEFINES_SVH
`define BYTE_BUDGET_LRU_CACHE_MANAGER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BBLCM_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cache manager check failed");

// Next-cycle implication, checked out of reset.
`define BBLCM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cache manager check failed");

`endif

>>> hw/rtl/bblcm_pkg.sv
package bblcm_pkg;

  localparam int KEY_W = 64;
  localparam int LEN_W = 32;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVICT_CHK,
    ST_EVICT,
    ST_APPEND,
    ST_FINAL
  } state_t;

  // Capacity minus usage, saturating at zero.
  function automatic logic [LEN_W-1:0] free_of(input logic [LEN_W-1:0] cap,
                                               input logic [LEN_W-1:0] used);
    return (cap >= used) ? (cap - used) : '0;
  endfunction

endpackage

>>> hw/rtl/byte_budget_lru_cache_manager.sv
// Channel   Handshake                         Payload
// --------  --------------------------------  ------------------------------------------
// request   start & !busy                      cmd, entry_key, entry_length
// result    done (one cycle, no backpressure)  hit, status, evicted, evicted_key,
//                                              evicted_length, free_bytes, last
// config    cfg_valid & cfg_ready              capacity_bytes
//
// One request at a time; busy is high until its final result is registered, and the
// next request is taken at the end of the first cycle with busy low.
// Lookup: scans the ranks from the least recent, one key compare per cycle through the
// single read port of the key/length memory, and stops early on a hit. Insert: the same
// scan, then per eviction a fit check that reads the oldest slot and a release, then a
// last fit check and an append. Clear, reject and unused codes go straight to the result.
// Synchronous reset empties the table at once; the receiver cannot stall.
`include "byte_budget_lru_cache_manager_defines.svh"

module byte_budget_lru_cache_manager
  import bblcm_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       cmd,
  input  logic [KEY_W-1:0] entry_key,
  input  logic [LEN_W-1:0] entry_length,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] capacity_bytes,
  output logic             done,
  output logic             hit,
  output logic             status,
  output logic             evicted,
  output logic [KEY_W-1:0] evicted_key,
  output logic [LEN_W-1:0] evicted_length,
  output logic [LEN_W-1:0] free_bytes,
  output logic             last
);

  localparam int SW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  state_t state, state_next;

  logic [LEN_W-1:0] cap_bytes;
  logic [LEN_W-1:0] used, used_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    p, p_next;
  logic             cmp_vld, cmp_vld_next;
  logic [SW-1:0]    cmp_p;
  logic [SW-1:0]    cmp_slot;
  logic             is_ins;
  logic [KEY_W-1:0] req_key;
  logic [LEN_W-1:0] req_len;
  logic             hit_q, hit_q_next;
  logic             status_q, status_q_next;

  // Rank-ordered slot list: order[0] is least recent, order[count..] are free.
  logic [SW-1:0] order [ENTRIES];
  logic [SW-1:0] ord_ptr;
  logic [SW-1:0] mem_addr;
  logic          rot_en;
  logic [SW-1:0] rot_lo, rot_hi, rot_slot;

  logic [KEY_W-1:0] mem_key [ENTRIES];
  logic [LEN_W-1:0] mem_len [ENTRIES];
  logic [KEY_W-1:0] rd_key;
  logic [LEN_W-1:0] rd_len;
  logic             mem_we;

  logic             accept;
  logic             hit_now;
  logic             scan_end;
  logic             need_evict;
  logic [LEN_W-1:0] free_now;

  logic             done_next, hit_next, status_next, evicted_next, last_next;
  logic [KEY_W-1:0] evicted_key_next;
  logic [LEN_W-1:0] evicted_length_next, free_bytes_next;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign accept    = start && !busy;
  assign free_now  = free_of(cap_bytes, used);
  assign hit_now   = cmp_vld && (rd_key == req_key);
  assign scan_end  = (p == count) && !cmp_vld;
  assign need_evict = (free_now < req_len) || (count == CW'(ENTRIES));
  assign mem_addr  = order[ord_ptr];

  always_comb begin
    unique case (state)
      ST_SCAN:   ord_ptr = p[SW-1:0];
      ST_APPEND: ord_ptr = count[SW-1:0];
      default:   ord_ptr = '0;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (cmd == CMD_LOOKUP) begin
            state_next = ST_SCAN;
          end else if (cmd == CMD_INSERT) begin
            state_next = (entry_length > cap_bytes) ? ST_FINAL : ST_SCAN;
          end else begin
            state_next = ST_FINAL;
          end
        end
      end
      ST_SCAN: begin
        if (hit_now || scan_end) begin
          state_next = is_ins ? ST_EVICT_CHK : ST_FINAL;
        end
      end
      ST_EVICT_CHK: begin
        state_next = (need_evict && (count != '0)) ? ST_EVICT : ST_APPEND;
      end
      ST_EVICT:  state_next = ST_EVICT_CHK;
      ST_APPEND: state_next = ST_IDLE;
      ST_FINAL:  state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Datapath controls and result fields
  always_comb begin
    used_next           = used;
    count_next          = count;
    p_next              = p;
    cmp_vld_next        = 1'b0;
    hit_q_next          = hit_q;
    status_q_next       = status_q;
    rot_en              = 1'b0;
    rot_lo              = '0;
    rot_hi              = SW'(ENTRIES - 1);
    rot_slot            = order[0];
    mem_we              = 1'b0;
    done_next           = 1'b0;
    hit_next            = 1'b0;
    status_next         = 1'b0;
    evicted_next        = 1'b0;
    evicted_key_next    = '0;
    evicted_length_next = '0;
    free_bytes_next     = free_now;
    last_next           = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          p_next        = '0;
          hit_q_next    = 1'b0;
          status_q_next = (cmd == CMD_INSERT) && (entry_length > cap_bytes);
          if (cmd == CMD_CLEAR) begin
            count_next = '0;
            used_next  = '0;
          end
        end
      end
      ST_SCAN: begin
        if (hit_now) begin
          rot_en   = 1'b1;
          rot_lo   = cmp_p;
          rot_slot = cmp_slot;
          if (is_ins) begin
            // drop the old copy; its bytes come back
            count_next = count - CW'(1);
            used_next  = used - rd_len;
          end else begin
            rot_hi     = SW'(count - CW'(1));
            hit_q_next = 1'b1;
          end
        end else if (p != count) begin
          p_next       = p + CW'(1);
          cmp_vld_next = 1'b1;
        end
      end
      ST_EVICT: begin
        rot_en              = 1'b1;
        count_next          = count - CW'(1);
        used_next           = used - rd_len;
        done_next           = 1'b1;
        evicted_next        = 1'b1;
        evicted_key_next    = rd_key;
        evicted_length_next = rd_len;
        free_bytes_next     = free_of(cap_bytes, used - rd_len);
      end
      ST_APPEND: begin
        if ((free_now >= req_len) && (count != CW'(ENTRIES))) begin
          mem_we     = 1'b1;
          count_next = count + CW'(1);
          used_next  = used + req_len;
        end
        done_next       = 1'b1;
        last_next       = 1'b1;
        free_bytes_next = free_of(cap_bytes, used_next);
      end
      ST_FINAL: begin
        done_next   = 1'b1;
        hit_next    = hit_q;
        status_next = status_q;
        last_next   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cap_bytes <= '0;
      used      <= '0;
      count     <= '0;
      p         <= '0;
      cmp_vld   <= 1'b0;
      hit_q     <= 1'b0;
      status_q  <= 1'b0;
      done      <= 1'b0;
    end else begin
      state    <= state_next;
      used     <= used_next;
      count    <= count_next;
      p        <= p_next;
      cmp_vld  <= cmp_vld_next;
      hit_q    <= hit_q_next;
      status_q <= status_q_next;
      done     <= done_next;
      if (cfg_valid && cfg_ready) begin
        cap_bytes <= capacity_bytes;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_p          <= p[SW-1:0];
    cmp_slot       <= mem_addr;
    hit            <= hit_next;
    status         <= status_next;
    evicted        <= evicted_next;
    evicted_key    <= evicted_key_next;
    evicted_length <= evicted_length_next;
    free_bytes     <= free_bytes_next;
    last           <= last_next;
    if (accept) begin
      is_ins  <= (cmd == CMD_INSERT);
      req_key <= entry_key;
      req_len <= entry_length;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_key[mem_addr] <= req_key;
      mem_len[mem_addr] <= req_len;
    end
    rd_key <= mem_key[mem_addr];
    rd_len <= mem_len[mem_addr];
  end

  // Rotate one rank segment left and park the moved slot at its top.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_order
    logic [SW-1:0] up;
    if (i < ENTRIES - 1) begin : g_mid
      assign up = order[i+1];
    end else begin : g_top
      assign up = order[i];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        order[i] <= SW'(i);
      end else if (rot_en) begin
        if (SW'(i) == rot_hi) begin
          order[i] <= rot_slot;
        end else if ((SW'(i) >= rot_lo) && (SW'(i) < rot_hi)) begin
          order[i] <= up;
        end
      end
    end
  end

  `BBLCM_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count <= CW'(ENTRIES))
  `BBLCM_ASSERT_IMPL(a_empty_no_bytes, clk, rst, count == '0, used == '0)
  `BBLCM_ASSERT_IMPL(a_evict_not_last, clk, rst, done && evicted, !last)
  `BBLCM_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done)

endmodule

>>> bench/byte_budget_lru_cache_manager_test.sv
`timescale 1ns / 100ps

module byte_budget_lru_cache_manager_test
  import bblcm_pkg::*;
();

  localparam int ENTRIES = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic             hit;
    logic             status;
    logic             evicted;
    logic [KEY_W-1:0] ekey;
    logic [LEN_W-1:0] elen;
    logic [LEN_W-1:0] room;
    logic             fin;
  } cache_result_t;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [1:0]       cmd;
  logic [KEY_W-1:0] entry_key;
  logic [LEN_W-1:0] entry_length;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [LEN_W-1:0] capacity_bytes;
  logic             done;
  logic             hit;
  logic             status;
  logic             evicted;
  logic [KEY_W-1:0] evicted_key;
  logic [LEN_W-1:0] evicted_length;
  logic [LEN_W-1:0] free_bytes;
  logic             last;

  // Cache image kept by the bench
  logic [KEY_W-1:0] tbl_key [ENTRIES];
  logic [LEN_W-1:0] tbl_len [ENTRIES];
  bit               tbl_live [ENTRIES];
  int unsigned      tbl_rank [ENTRIES];
  logic [LEN_W-1:0] tbl_used;
  logic [LEN_W-1:0] budget;

  cache_result_t pending_results [$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  bit            no_gaps;

  byte_budget_lru_cache_manager #(.ENTRIES(ENTRIES)) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .entry_key     (entry_key),
    .entry_length  (entry_length),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .capacity_bytes(capacity_bytes),
    .done          (done),
    .hit           (hit),
    .status        (status),
    .evicted       (evicted),
    .evicted_key   (evicted_key),
    .evicted_length(evicted_length),
    .free_bytes    (free_bytes),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [LEN_W-1:0] room_left();
    return (budget >= tbl_used) ? budget - tbl_used : '0;
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    foreach (tbl_live[i]) if (tbl_live[i]) n++;
    return n;
  endfunction

  function automatic int slot_of_key(input logic [KEY_W-1:0] key);
    foreach (tbl_live[i]) if (tbl_live[i] && tbl_key[i] == key) return i;
    return -1;
  endfunction

  function automatic int oldest_slot();
    foreach (tbl_live[i]) if (tbl_live[i] && tbl_rank[i] == 0) return i;
    return -1;
  endfunction

  function automatic int empty_slot();
    foreach (tbl_live[i]) if (!tbl_live[i]) return i;
    return -1;
  endfunction

  function automatic void release_slot(input int s);
    int unsigned r;
    r = tbl_rank[s];
    tbl_live[s] = 1'b0;
    tbl_rank[s] = 0;
    tbl_used = tbl_used - tbl_len[s];
    foreach (tbl_live[i]) if (tbl_live[i] && tbl_rank[i] > r) tbl_rank[i]--;
  endfunction

  function automatic void promote_slot(input int s);
    int unsigned r;
    int n;
    r = tbl_rank[s];
    n = live_count();
    foreach (tbl_live[i])
      if (i != s && tbl_live[i] && tbl_rank[i] > r) tbl_rank[i]--;
    tbl_rank[s] = n - 1;
  endfunction

  function automatic void queue_result(input logic h, input logic st, input logic ev,
                                       input logic [KEY_W-1:0] k, input logic [LEN_W-1:0] l,
                                       input logic fin);
    cache_result_t r;
    r.hit = h;
    r.status = st;
    r.evicted = ev;
    r.ekey = k;
    r.elen = l;
    r.room = room_left();
    r.fin = fin;
    pending_results = {pending_results, r};
  endfunction

  function automatic void predict_cache_op(input logic [1:0] op, input logic [KEY_W-1:0] key,
                                           input logic [LEN_W-1:0] len);
    int s;
    logic [KEY_W-1:0] gone_key;
    logic [LEN_W-1:0] gone_len;
    case (op)
      CMD_LOOKUP: begin
        s = slot_of_key(key);
        if (s >= 0) promote_slot(s);
        queue_result(s >= 0, 1'b0, 1'b0, '0, '0, 1'b1);
      end
      CMD_CLEAR: begin
        foreach (tbl_live[i]) begin
          tbl_live[i] = 1'b0;
          tbl_rank[i] = 0;
        end
        tbl_used = '0;
        queue_result(1'b0, 1'b0, 1'b0, '0, '0, 1'b1);
      end
      CMD_INSERT: begin
        if (len > budget) begin
          queue_result(1'b0, 1'b1, 1'b0, '0, '0, 1'b1);
        end else begin
          s = slot_of_key(key);
          if (s >= 0) release_slot(s);
          // evict oldest until the bytes fit and a slot is open
          s = 0;
          while (s >= 0 && (room_left() < len || live_count() >= ENTRIES)) begin
            s = oldest_slot();
            if (s >= 0) begin
              gone_key = tbl_key[s];
              gone_len = tbl_len[s];
              release_slot(s);
              queue_result(1'b0, 1'b0, 1'b1, gone_key, gone_len, 1'b0);
            end
          end
          s = empty_slot();
          if (s >= 0 && room_left() >= len) begin
            tbl_rank[s] = live_count();
            tbl_key[s] = key;
            tbl_len[s] = len;
            tbl_live[s] = 1'b1;
            tbl_used = tbl_used + len;
          end
          queue_result(1'b0, 1'b0, 1'b0, '0, '0, 1'b1);
        end
      end
      default: queue_result(1'b0, 1'b0, 1'b0, '0, '0, 1'b1);
    endcase
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    cache_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with none expected, actual evicted %0b key %0h free %0h",
                 $time, evicted, evicted_key, free_bytes);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit", want.hit, hit);
        check_field("status", want.status, status);
        check_field("evicted", want.evicted, evicted);
        check_field("evicted_key", want.ekey, evicted_key);
        check_field("evicted_length", want.elen, evicted_length);
        check_field("free_bytes", want.room, free_bytes);
        check_field("last", want.fin, last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [KEY_W-1:0] key,
                              input logic [LEN_W-1:0] len);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= op;
    entry_key <= key;
    entry_length <= len;
    do @(posedge clk); while (busy);
    predict_cache_op(op, key, len);
  endtask

  task automatic wait_until_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [LEN_W-1:0] value);
    cfg_valid <= 1'b1;
    capacity_bytes <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    budget = value;
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 10) return '0;
    if (p < 40) return $urandom_range(0, 255);
    if (p < 70) return $urandom_range(0, budget / 4);
    if (p < 78) return budget;
    if (p < 86 && budget != '1) return budget + 1;
    return $urandom();
  endfunction

  // Zero budget straight out of reset
  task automatic test_empty_table();
    set_capacity('0);
    send_request(CMD_LOOKUP, 64'h0, '0);
    send_request(CMD_INSERT, 64'h0, '0);
    send_request(CMD_LOOKUP, 64'h0, '0);
    send_request(CMD_INSERT, 64'h1, 32'd1);
    send_request(CMD_UNUSED, 64'h0, '0);
    send_request(CMD_CLEAR, 64'h0, '0);
  endtask

  task automatic test_lru_order();
    wait_until_drained();
    set_capacity(32'd100);
    send_request(CMD_INSERT, 64'hA, 32'd40);
    send_request(CMD_INSERT, 64'hB, 32'd30);
    send_request(CMD_INSERT, 64'hC, 32'd30);
    send_request(CMD_LOOKUP, 64'hA, '0);
    send_request(CMD_INSERT, 64'hD, 32'd20);
    send_request(CMD_INSERT, 64'hC, 32'd50);
    // oversize insert of a present key leaves it alone
    send_request(CMD_INSERT, 64'hD, 32'd101);
  endtask

  task automatic test_capacity_below_usage();
    wait_until_drained();
    set_capacity(32'd10);
    send_request(CMD_LOOKUP, 64'hD, '0);
    send_request(CMD_INSERT, 64'hE, 32'd5);
  endtask

  task automatic test_full_range();
    wait_until_drained();
    set_capacity('1);
    send_request(CMD_INSERT, '1, '1);
    send_request(CMD_LOOKUP, '1, '1);
    send_request(CMD_INSERT, '0, '0);
    send_request(CMD_CLEAR, '1, '1);
  endtask

  task automatic run_random_phase(input logic [LEN_W-1:0] cap, input int n_items,
                                  input int clear_pct);
    logic [KEY_W-1:0] key_pool [24];
    logic [KEY_W-1:0] key;
    logic [1:0] op;
    int unsigned p;
    wait_until_drained();
    set_capacity(cap);
    foreach (key_pool[i]) key_pool[i] = {$urandom(), $urandom()};
    repeat (n_items) begin
      if ($urandom_range(0, 9) == 0) no_gaps = !no_gaps;
      p = $urandom_range(0, 99);
      if (p < clear_pct) op = CMD_CLEAR;
      else if (p < clear_pct + 3) op = CMD_UNUSED;
      else if (p < 55) op = CMD_INSERT;
      else op = CMD_LOOKUP;
      // mostly reuse a small key set so lookups hit and re-inserts happen
      if ($urandom_range(0, 9) < 8) key = key_pool[$urandom_range(0, 23)];
      else key = {$urandom(), $urandom()};
      send_request(op, key, pick_length());
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(32'd300, 32, 3);
    run_random_phase('1, 32, 0);
    run_random_phase('0, 16, 5);
    run_random_phase($urandom(), 32, 3);
    run_random_phase(32'd5000, 24, 0);
    run_random_phase(32'd60, 24, 3);
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= CMD_LOOKUP;
    entry_key <= '0;
    entry_length <= '0;
    cfg_valid <= 1'b0;
    capacity_bytes <= '0;
    foreach (tbl_live[i]) begin
      tbl_live[i] = 1'b0;
      tbl_rank[i] = 0;
    end
    tbl_used = '0;
    budget = '0;
    no_gaps = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_lru_order();
    test_capacity_below_usage();
    test_full_range();
    test_random_traffic();

    wait_until_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/bblcm_pkg.sv
hw/rtl/byte_budget_lru_cache_manager.sv
bench/byte_budget_lru_cache_manager_test.sv
